// File: rtl/sab_pkg.sv
package sab_pkg;

  localparam int MAX_STATES_DEF = 2048;
  localparam int ALPHABET_DEF   = 26;
  localparam int SYM_W          = 5;
  localparam int SYMX_W         = 7;
  localparam int STATUS_W       = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_TRANS = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SYM  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_T_CHK,
    S_X_LEN_WR,
    S_X_ZERO,
    S_WALK_RD,
    S_WALK_CHK,
    S_Q_RD,
    S_Q_CHK,
    S_CP_RD,
    S_CP_WR,
    S_LINKQ,
    S_LINKNP,
    S_RD_RD,
    S_RD_CHK
  } ctrl_state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR_ROOT,
    CMD_LATCH,
    CMD_BAD,
    CMD_FULL,
    CMD_T_RD,
    CMD_T_CHK,
    CMD_X_LEN_RD,
    CMD_X_LEN_WR,
    CMD_X_ZERO,
    CMD_WALK_RD,
    CMD_WALK_CHK,
    CMD_Q_RD,
    CMD_Q_CHK,
    CMD_CP_RD,
    CMD_CP_WR,
    CMD_LINKQ,
    CMD_LINKNP,
    CMD_RD_RD,
    CMD_RD_CHK,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    logic sym_bad;
    logic op;
    logic full;
    logic k_last;
    logic t_zero;
    logic p_zero;
    logic t_eq_q;
    logic len_match;
  } dp_status_t;

endpackage

// File: rtl/sab_ram.sv
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/sab_ctrl.sv
module sab_ctrl
  import sab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t st_i,
  output dp_cmd_e    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  logic resp_q, resp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_q <= 1'b0;
    end else begin
      resp_q <= resp_d;
    end
  end

  always_comb begin
    state_d = state_q;
    resp_d  = 1'b0;
    case (state_q)
      S_CLR:      if (st_i.k_last) state_d = S_IDLE;
      S_IDLE:     if (start_i && !resp_q) state_d = S_DECODE;
      S_DECODE: begin
        if (st_i.sym_bad || (!st_i.op && st_i.full)) begin
          state_d = S_IDLE;
          resp_d  = 1'b1;
        end else if (st_i.op) begin
          state_d = S_T_CHK;
        end else begin
          state_d = S_X_LEN_WR;
        end
      end
      S_T_CHK: begin
        state_d = S_IDLE;
        resp_d  = 1'b1;
      end
      S_X_LEN_WR: state_d = S_X_ZERO;
      S_X_ZERO:   if (st_i.k_last) state_d = S_WALK_RD;
      S_WALK_RD:  state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (!st_i.t_zero) begin
          state_d = S_Q_RD;
        end else if (st_i.p_zero) begin
          state_d = S_IDLE;
          resp_d  = 1'b1;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_Q_RD:     state_d = S_Q_CHK;
      S_Q_CHK: begin
        if (st_i.len_match) begin
          state_d = S_IDLE;
          resp_d  = 1'b1;
        end else begin
          state_d = S_CP_RD;
        end
      end
      S_CP_RD:    state_d = S_CP_WR;
      S_CP_WR:    state_d = st_i.k_last ? S_LINKQ : S_CP_RD;
      S_LINKQ:    state_d = S_LINKNP;
      S_LINKNP:   state_d = S_RD_RD;
      S_RD_RD:    state_d = S_RD_CHK;
      S_RD_CHK: begin
        if (!st_i.t_eq_q || st_i.p_zero) begin
          state_d = S_IDLE;
          resp_d  = 1'b1;
        end else begin
          state_d = S_RD_RD;
        end
      end
      default:    state_d = S_CLR;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      S_CLR:      cmd_o = CMD_CLR_ROOT;
      S_IDLE:     cmd_o = (start_i && !resp_q) ? CMD_LATCH : CMD_NONE;
      S_DECODE: begin
        if (st_i.sym_bad)   cmd_o = CMD_BAD;
        else if (st_i.op)   cmd_o = CMD_T_RD;
        else if (st_i.full) cmd_o = CMD_FULL;
        else                cmd_o = CMD_X_LEN_RD;
      end
      S_T_CHK:    cmd_o = CMD_T_CHK;
      S_X_LEN_WR: cmd_o = CMD_X_LEN_WR;
      S_X_ZERO:   cmd_o = CMD_X_ZERO;
      S_WALK_RD:  cmd_o = CMD_WALK_RD;
      S_WALK_CHK: cmd_o = (st_i.t_zero && st_i.p_zero) ? CMD_FINISH : CMD_WALK_CHK;
      S_Q_RD:     cmd_o = CMD_Q_RD;
      S_Q_CHK:    cmd_o = CMD_Q_CHK;
      S_CP_RD:    cmd_o = CMD_CP_RD;
      S_CP_WR:    cmd_o = CMD_CP_WR;
      S_LINKQ:    cmd_o = CMD_LINKQ;
      S_LINKNP:   cmd_o = CMD_LINKNP;
      S_RD_RD:    cmd_o = CMD_RD_RD;
      S_RD_CHK:   cmd_o = CMD_RD_CHK;
      default:    cmd_o = CMD_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE) || resp_q;
  assign done_o = resp_q;

endmodule

// File: rtl/sab_dp.sv
module sab_dp
  import sab_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          operation_i,
  input  logic [SYM_W-1:0]              symbol_i,
  input  dp_cmd_e                       cmd_i,
  output dp_status_t                    st_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic [$clog2(MAX_STATES)-1:0] cursor_state_o,
  output logic [$clog2(MAX_STATES)-1:0] last_state_o,
  output logic [$clog2(MAX_STATES):0]   states_used_o
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = SW + 1;
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int TD = MAX_STATES << AW;

  logic [SW-1:0] cursor_q, last_q, p_q, q_q, np_q, nq_q, lenp_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] k_q, sym_q;
  logic          op_q, bad_q;
  status_e       status_q;

  logic [SW-1:0]    tr_rd, ln_rd, lk_rd;
  logic             tr_we, ln_we, lk_we;
  logic [SW+AW-1:0] tr_wa, tr_ra;
  logic [SW-1:0]    tr_wd, ln_wa, ln_wd, ln_ra, lk_wa, lk_wd, lk_ra;

  logic [SYMX_W-1:0] sym_ext;
  logic              k_last;

  assign sym_ext = {{(SYMX_W-SYM_W){1'b0}}, symbol_i};
  assign k_last  = (k_q == AW'(ALPHABET - 1));

  assign st_o.sym_bad   = bad_q;
  assign st_o.op        = op_q;
  assign st_o.full      = (({1'b0, count_q} + (CW+1)'(2)) > (CW+1)'(MAX_STATES));
  assign st_o.k_last    = k_last;
  assign st_o.t_zero    = (tr_rd == '0);
  assign st_o.p_zero    = (p_q == '0);
  assign st_o.t_eq_q    = (tr_rd == q_q);
  assign st_o.len_match = ((lenp_q + SW'(1)) == ln_rd);

  always_comb begin
    tr_we = 1'b0; tr_wa = {p_q, sym_q}; tr_wd = np_q; tr_ra = {p_q, sym_q};
    ln_we = 1'b0; ln_wa = np_q; ln_wd = ln_rd + SW'(1); ln_ra = p_q;
    lk_we = 1'b0; lk_wa = np_q; lk_wd = '0; lk_ra = p_q;
    case (cmd_i)
      CMD_CLR_ROOT: begin
        tr_we = 1'b1; tr_wa = {SW'(0), k_q}; tr_wd = '0;
        ln_we = 1'b1; ln_wa = '0; ln_wd = '0;
      end
      CMD_T_RD:     tr_ra = {cursor_q, sym_q};
      CMD_X_LEN_RD: ln_ra = last_q;
      CMD_X_LEN_WR: begin
        ln_we = 1'b1;
        lk_we = 1'b1;
      end
      CMD_X_ZERO: begin
        tr_we = 1'b1; tr_wa = {np_q, k_q}; tr_wd = '0;
      end
      CMD_WALK_CHK, CMD_FINISH: begin
        tr_we = st_o.t_zero;
      end
      CMD_Q_RD: begin
        ln_ra = q_q;
        lk_ra = q_q;
      end
      CMD_Q_CHK: begin
        if (st_o.len_match) begin
          lk_we = 1'b1; lk_wa = np_q; lk_wd = q_q;
        end else begin
          ln_we = 1'b1; ln_wa = count_q[SW-1:0]; ln_wd = lenp_q + SW'(1);
          lk_we = 1'b1; lk_wa = count_q[SW-1:0]; lk_wd = lk_rd;
        end
      end
      CMD_CP_RD:    tr_ra = {q_q, k_q};
      CMD_CP_WR: begin
        tr_we = 1'b1; tr_wa = {nq_q, k_q}; tr_wd = tr_rd;
      end
      CMD_LINKQ: begin
        lk_we = 1'b1; lk_wa = q_q; lk_wd = nq_q;
      end
      CMD_LINKNP: begin
        lk_we = 1'b1; lk_wa = np_q; lk_wd = nq_q;
      end
      CMD_RD_CHK: begin
        tr_we = st_o.t_eq_q; tr_wd = nq_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      last_q   <= '0;
      count_q  <= CW'(1);
      k_q      <= '0;
      status_q <= ST_OK;
    end else begin
      case (cmd_i)
        CMD_CLR_ROOT, CMD_X_ZERO, CMD_CP_WR: k_q <= k_last ? '0 : k_q + AW'(1);
        CMD_LATCH: begin
          k_q <= '0;
        end
        CMD_BAD:  status_q <= ST_BAD_SYM;
        CMD_FULL: status_q <= ST_FULL;
        CMD_T_CHK: begin
          if (st_o.t_zero) begin
            status_q <= ST_NO_TRANS;
          end else begin
            status_q <= ST_OK;
            cursor_q <= tr_rd;
          end
        end
        CMD_X_LEN_RD: count_q <= count_q + CW'(1);
        CMD_Q_CHK: begin
          if (st_o.len_match) begin
            last_q   <= np_q;
            status_q <= ST_OK;
          end else begin
            count_q <= count_q + CW'(1);
          end
          k_q <= '0;
        end
        CMD_FINISH: begin
          last_q   <= np_q;
          status_q <= ST_OK;
        end
        CMD_RD_CHK: begin
          if (!st_o.t_eq_q || st_o.p_zero) begin
            last_q   <= np_q;
            status_q <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        op_q  <= operation_i;
        bad_q <= (sym_ext >= SYMX_W'(ALPHABET));
        sym_q <= sym_ext[AW-1:0];
      end
      CMD_X_LEN_RD: begin
        np_q <= count_q[SW-1:0];
        p_q  <= last_q;
      end
      CMD_WALK_RD: lenp_q <= lenp_q;
      CMD_WALK_CHK: begin
        if (st_o.t_zero) begin
          p_q <= lk_rd;
        end else begin
          q_q    <= tr_rd;
          lenp_q <= ln_rd;
        end
      end
      CMD_Q_CHK:  nq_q <= count_q[SW-1:0];
      CMD_RD_CHK: p_q  <= lk_rd;
      default: ;
    endcase
  end

  sab_ram #(.WIDTH(SW), .DEPTH(TD)) u_trans (
    .clk_i(clk_i), .we_i(tr_we), .waddr_i(tr_wa), .wdata_i(tr_wd),
    .raddr_i(tr_ra), .rdata_o(tr_rd)
  );

  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_len (
    .clk_i(clk_i), .we_i(ln_we), .waddr_i(ln_wa), .wdata_i(ln_wd),
    .raddr_i(ln_ra), .rdata_o(ln_rd)
  );

  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_link (
    .clk_i(clk_i), .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd),
    .raddr_i(lk_ra), .rdata_o(lk_rd)
  );

  assign status_o       = status_q;
  assign cursor_state_o = cursor_q;
  assign last_state_o   = last_q;
  assign states_used_o  = count_q;

endmodule

// File: rtl/suffix_automaton_builder_core.sv
// Transit: latch, decode, transition check. Extend: the new state's row is cleared per
// symbol, the suffix-link walk reads one transition per step, a stop on an existing
// transition checks lengths, and a clone copies the row, links, then redirects.
// One transaction at a time; done_o is a one-cycle strobe, the receiver cannot stall.
// After reset the root row is cleared with busy_o high.
module suffix_automaton_builder_core
  import sab_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [SYM_W-1:0]              symbol_i,
  output logic                          done_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic [$clog2(MAX_STATES)-1:0] cursor_state_o,
  output logic [$clog2(MAX_STATES)-1:0] last_state_o,
  output logic [$clog2(MAX_STATES):0]   states_used_o
);

  dp_cmd_e    cmd;
  dp_status_t st;

  sab_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .st_i(st),
    .cmd_o(cmd), .busy_o(busy_o), .done_o(done_o)
  );

  sab_dp #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .operation_i(operation_i), .symbol_i(symbol_i),
    .cmd_i(cmd), .st_o(st), .status_o(status_o), .cursor_state_o(cursor_state_o),
    .last_state_o(last_state_o), .states_used_o(states_used_o)
  );

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted transaction not busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (states_used_o != '0) && (int'(states_used_o) <= MAX_STATES))
    else $error("state count out of range");

endmodule
